### src/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg: shared types and constants of the hysteresis thermostat
// Payload words, configuration struct, status and register codes.
// ----------------------------------------------------------------------------
package hts_pkg;

	localparam int TEMP_W     = 16;
	localparam int HYST_W     = 14;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;
	localparam int SUM_W      = TEMP_W + 2;

	localparam logic signed [TEMP_W-1:0] TEMP_LOW_LIMIT  = -16'sd4000;
	localparam logic signed [TEMP_W-1:0] TEMP_HIGH_LIMIT = 16'sd12000;

	localparam logic [HYST_W-1:0] HYST_RESET = 14'd100;

	typedef enum logic [2:0] {
		ST_NORMAL     = 3'd0,
		ST_BACKUP     = 3'd1,
		ST_BACKUP_ERR = 3'd2,
		ST_SENSOR_ERR = 3'd3,
		ST_CONFIG_ERR = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HYSTERESIS        = 3'd0,
		REG_DIRECTION_REVERSE = 3'd1,
		REG_CONTROL_ENABLED   = 3'd2,
		REG_BACKUP_ENABLED    = 3'd3,
		REG_RELAY_CONFIGURED  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] setpoint;
		logic signed [TEMP_W-1:0] main_temp;
		logic signed [TEMP_W-1:0] backup_temp;
	} sample_t;

	typedef struct packed {
		logic    relay_level;
		logic    relay_written;
		status_t status;
		logic    status_written;
	} result_t;

	typedef struct packed {
		logic [HYST_W-1:0] hysteresis;
		logic              direction_reverse;
		logic              control_enabled;
		logic              backup_enabled;
		logic              relay_configured;
	} cfg_t;

	function automatic logic reading_valid(input logic signed [TEMP_W-1:0] t);
		return (t > TEMP_LOW_LIMIT) && (t < TEMP_HIGH_LIMIT) && (t != '0);
	endfunction

endpackage

### src/hts_cfg.sv
// ----------------------------------------------------------------------------
// hts_cfg: configuration register file
// Takes register writes by index and presents the settings as one struct.
// ----------------------------------------------------------------------------
module hts_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hts_pkg::CFG_DATA_W-1:0]   cfg_data,
	output hts_pkg::cfg_t                    cfg
);

	hts_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hysteresis        <= hts_pkg::HYST_RESET;
			cfg_q.direction_reverse <= 1'b0;
			cfg_q.control_enabled   <= 1'b1;
			cfg_q.backup_enabled    <= 1'b0;
			cfg_q.relay_configured  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hts_pkg::REG_HYSTERESIS:
					cfg_q.hysteresis <= cfg_data[hts_pkg::HYST_W-1:0];
				hts_pkg::REG_DIRECTION_REVERSE: cfg_q.direction_reverse <= cfg_data[0];
				hts_pkg::REG_CONTROL_ENABLED:   cfg_q.control_enabled   <= cfg_data[0];
				hts_pkg::REG_BACKUP_ENABLED:    cfg_q.backup_enabled    <= cfg_data[0];
				hts_pkg::REG_RELAY_CONFIGURED:  cfg_q.relay_configured  <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

### src/hts_eval.sv
// ----------------------------------------------------------------------------
// hts_eval: per-tick thermostat decision
// Picks the sensor, sets the status code and applies the hysteresis rules.
// ----------------------------------------------------------------------------
module hts_eval (
	input  hts_pkg::sample_t sample,
	input  hts_pkg::cfg_t    cfg,
	input  logic             relay_state,
	output hts_pkg::result_t result,
	output logic             relay_next
);

	logic                                cfg_err;
	logic                                main_ok;
	logic                                back_ok;
	logic                                have_temp;
	logic                                drive;
	logic                                hi_hit;
	logic                                lo_hit;
	logic signed [hts_pkg::TEMP_W-1:0]   temp;
	logic signed [hts_pkg::SUM_W-1:0]    temp_x;
	logic signed [hts_pkg::SUM_W-1:0]    sp_x;
	logic signed [hts_pkg::SUM_W-1:0]    hyst_x;
	hts_pkg::status_t                    status;

	always_comb begin
		cfg_err = (sample.setpoint == '0) || !cfg.relay_configured;
		main_ok = hts_pkg::reading_valid(sample.main_temp);
		back_ok = hts_pkg::reading_valid(sample.backup_temp);

		priority if (cfg_err)
			status = hts_pkg::ST_CONFIG_ERR;
		else if (main_ok)
			status = hts_pkg::ST_NORMAL;
		else if (!cfg.backup_enabled)
			status = hts_pkg::ST_SENSOR_ERR;
		else if (back_ok)
			status = hts_pkg::ST_BACKUP;
		else
			status = hts_pkg::ST_BACKUP_ERR;

		have_temp = !cfg_err && (main_ok || (cfg.backup_enabled && back_ok));
		drive     = have_temp && cfg.control_enabled;
		temp      = main_ok ? sample.main_temp : sample.backup_temp;

		temp_x = hts_pkg::SUM_W'(temp);
		sp_x   = hts_pkg::SUM_W'(sample.setpoint);
		hyst_x = $signed({{(hts_pkg::SUM_W - hts_pkg::HYST_W){1'b0}}, cfg.hysteresis});
		hi_hit = temp_x >= (sp_x + hyst_x);
		lo_hit = temp_x <= (sp_x - hyst_x);

		priority if (drive && lo_hit)
			relay_next = cfg.direction_reverse;
		else if (drive && hi_hit)
			relay_next = !cfg.direction_reverse;
		else
			relay_next = relay_state;

		result.relay_level    = relay_next;
		result.relay_written  = drive && (hi_hit || lo_hit);
		result.status         = status;
		result.status_written = cfg_err || cfg.control_enabled;
	end

endmodule

### src/hysteresis_thermostat_backup_sensor.sv
// ----------------------------------------------------------------------------
// hysteresis_thermostat_backup_sensor: bang-bang thermostat with backup sensor
// Two-stage datapath: sample register, decision logic, result register.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel (sample_valid / sample_stall / sample) carries one word per
//   tick: setpoint, main and backup temperatures, signed hundredths.
//   result channel (result_valid / result_stall / result) returns one word per
//   tick: relay level, relay written flag, status code, status written flag.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes one
//   register per handshake; cfg_ready is always high. Write only while idle.
// Path: a sample is registered in the sample register, then its result in the result register.
// Throughput: one word per cycle; the sample register and the result register
//   advance together, so a word is accepted each cycle the result side moves.
// Stall: while result_stall holds a full result register, the sample register
//   holds too and sample_stall rises once it is occupied.
// Reset: relay level off, registers at their defaults, both stages empty.
// ----------------------------------------------------------------------------
module hysteresis_thermostat_backup_sensor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  hts_pkg::sample_t                sample,
	output logic                            result_valid,
	input  logic                            result_stall,
	output hts_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hts_pkg::CFG_DATA_W-1:0]  cfg_data
);

	hts_pkg::cfg_t    cfg;
	hts_pkg::sample_t sample_s1;
	hts_pkg::result_t result_s2;
	hts_pkg::result_t eval_result;
	logic             valid_s1;
	logic             valid_s2;
	logic             relay_q;
	logic             relay_next;
	logic             advance_s1;
	logic             take_in;

	hts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hts_eval u_eval (
		.sample      (sample_s1),
		.cfg         (cfg),
		.relay_state (relay_q),
		.result      (eval_result),
		.relay_next  (relay_next)
	);

	assign advance_s1   = valid_s1 && (!valid_s2 || !result_stall);
	assign sample_stall = valid_s1 && !advance_s1;
	assign take_in      = sample_valid && !sample_stall;
	assign result_valid = valid_s2;
	assign result       = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			relay_q  <= 1'b0;
		end else begin
			if (take_in)
				valid_s1 <= 1'b1;
			else if (advance_s1)
				valid_s1 <= 1'b0;
			if (advance_s1) begin
				valid_s2 <= 1'b1;
				relay_q  <= relay_next;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in)
			sample_s1 <= sample;
		if (advance_s1)
			result_s2 <= eval_result;
	end

	a_level_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> result_s2.relay_level == relay_q)
		else $error("held result level differs from relay state");

	a_hold_unwritten: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && !eval_result.relay_written |=> relay_q == $past(relay_q))
		else $error("relay changed without a threshold rule");

	a_config_err: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.status == hts_pkg::ST_CONFIG_ERR
		|-> result_s2.status_written && !result_s2.relay_written)
		else $error("config error word drove the relay or was not reported");

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1 && valid_s2 && result_stall)
		else $error("sample stalled with room in the pipeline");

endmodule
